FILE: rtl/core/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg: shared types and constants for the LRU key-value cache
// Beat payloads of the request and response channels, operation codes and
// the reset value of the capacity limit register.
// ----------------------------------------------------------------------------
`default_nettype none

package lkv_pkg;

    localparam int KEY_WIDTH        = 32;
    localparam int VALUE_WIDTH      = 32;
    localparam int CAPACITY_DEFAULT = 16;
    localparam int CFG_WIDTH        = 5;
    localparam int OCC_WIDTH        = 5;

    localparam logic [CFG_WIDTH-1:0] LIMIT_RESET = 5'd16;

    // Operation codes carried in the mode field.
    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_ERASE  = 2'd2;

    typedef struct packed {
        logic [1:0]             mode;
        logic [KEY_WIDTH-1:0]   key_in;
        logic [VALUE_WIDTH-1:0] value_in;
    } lkv_req_t;

    typedef struct packed {
        logic                   hit;
        logic [VALUE_WIDTH-1:0] value_out;
        logic                   inserted;
        logic                   evicted;
        logic [KEY_WIDTH-1:0]   evicted_key;
        logic [OCC_WIDTH-1:0]   occupancy;
    } lkv_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/lru_key_value_cache.sv
// Response: formed combinationally and registered in the output buffer.
// Throughput: one operation per cycle while req_stall is low; the match, replacement
// choice and age update of all entries are combinational, and a skid stage absorbs
// one stalled beat. Reset: all entries become invalid, occupancy goes to zero and the
// capacity limit returns to 16; entry keys and values are not cleared.
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value cache with LRU replacement
// Lookup, insert and erase by key over up to CAPACITY entries, with a
// programmable limit on the number of entries held.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache #(
    parameter int CAPACITY = lkv_pkg::CAPACITY_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [lkv_pkg::CFG_WIDTH-1:0] cfg_wr_data,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  lkv_pkg::lkv_req_t             req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output lkv_pkg::lkv_rsp_t             rsp
);

    logic              accept;
    lkv_pkg::lkv_rsp_t result;

    assign accept = req_valid && !req_stall;

    lkv_engine #(
        .CAPACITY (CAPACITY)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .req         (req),
        .rsp         (result)
    );

    lkv_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (req_valid),
        .push_data  (result),
        .push_stall (req_stall),
        .pop_valid  (rsp_valid),
        .pop_stall  (rsp_stall),
        .pop_data   (rsp)
    );

endmodule

`default_nettype wire

FILE: rtl/core/lkv_engine.sv
// ----------------------------------------------------------------------------
// lkv_engine: entry storage, parallel key match and recency update
// Holds every entry in flops, compares the request key against all of them
// at once and applies one operation per accepted beat.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_engine #(
    parameter int CAPACITY = lkv_pkg::CAPACITY_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [lkv_pkg::CFG_WIDTH-1:0]  cfg_wr_data,
    input  logic                           accept,
    input  lkv_pkg::lkv_req_t              req,
    output lkv_pkg::lkv_rsp_t              rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = CW + lkv_pkg::CFG_WIDTH;

    logic [lkv_pkg::KEY_WIDTH-1:0]   key_reg   [CAPACITY];
    logic [lkv_pkg::VALUE_WIDTH-1:0] value_reg [CAPACITY];
    logic [CAPACITY-1:0]             valid_reg;
    logic [CAPACITY-1:0]             valid_next;
    logic [AW-1:0]                   age_reg   [CAPACITY];
    logic [AW-1:0]                   age_next  [CAPACITY];
    logic [CW-1:0]                   count_reg;
    logic [CW-1:0]                   count_next;
    logic [lkv_pkg::CFG_WIDTH-1:0]   limit_reg;

    logic [CAPACITY-1:0]             match;
    logic [CAPACITY-1:0]             evict_sel;
    logic [CAPACITY-1:0]             free_sel;
    logic [CAPACITY-1:0]             new_sel;
    logic                            hit;
    logic [AW-1:0]                   hit_age;
    logic [lkv_pkg::VALUE_WIDTH-1:0] hit_value;
    logic [lkv_pkg::KEY_WIDTH-1:0]   evict_key;
    logic [CW-1:0]                   count_m1;
    logic [XW-1:0]                   count_x;
    logic [XW-1:0]                   limit_x;
    logic [XW-1:0]                   cap_x;
    logic [XW-1:0]                   eff_limit;
    logic [XW-1:0]                   occ_x;
    logic                            full;
    logic                            is_lookup;
    logic                            is_insert;
    logic                            is_erase;
    logic                            hit_op;
    logic                            do_touch;
    logic                            do_erase;
    logic                            do_insert;
    logic                            do_evict;

    always_comb
    begin
        is_lookup = 1'b0;
        is_insert = 1'b0;
        is_erase  = 1'b0;
        unique case (req.mode)
            lkv_pkg::MODE_LOOKUP: is_lookup = 1'b1;
            lkv_pkg::MODE_INSERT: is_insert = 1'b1;
            lkv_pkg::MODE_ERASE:  is_erase  = 1'b1;
            default:
            begin
                is_lookup = 1'b0;
            end
        endcase

        // Ages of valid entries are distinct and run from 0 to count-1, so the
        // least recently used entry is the one whose age equals count-1.
        count_m1 = count_reg - CW'(1);
        for (int i = 0; i < CAPACITY; i++)
        begin
            match[i]     = valid_reg[i] && (key_reg[i] == req.key_in);
            evict_sel[i] = valid_reg[i] && (age_reg[i] == count_m1[AW-1:0]);
        end

        // Lowest-numbered free slot as a one-hot vector.
        free_sel = ~valid_reg & (valid_reg + CAPACITY'(1));

        hit       = |match;
        hit_age   = '0;
        hit_value = '0;
        evict_key = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (match[i])
            begin
                hit_age   = hit_age | age_reg[i];
                hit_value = hit_value | value_reg[i];
            end
            if (evict_sel[i])
            begin
                evict_key = evict_key | key_reg[i];
            end
        end

        cap_x   = XW'(CAPACITY);
        limit_x = XW'(limit_reg);
        count_x = XW'(count_reg);
        priority if (limit_x == '0)
            eff_limit = XW'(1);
        else if (limit_x > cap_x)
            eff_limit = cap_x;
        else
            eff_limit = limit_x;
        full = (count_x >= eff_limit);

        hit_op    = hit && (is_lookup || is_insert || is_erase);
        do_touch  = hit && (is_lookup || is_insert);
        do_erase  = hit && is_erase;
        do_insert = !hit && is_insert;
        do_evict  = do_insert && full;
        new_sel   = do_evict ? evict_sel : free_sel;

        valid_next = valid_reg;
        count_next = count_reg;
        for (int i = 0; i < CAPACITY; i++)
        begin
            age_next[i] = age_reg[i];
            if (do_touch)
            begin
                if (match[i])
                    age_next[i] = '0;
                else if (valid_reg[i] && (age_reg[i] < hit_age))
                    age_next[i] = age_reg[i] + AW'(1);
            end
            else if (do_erase)
            begin
                if (match[i])
                begin
                    valid_next[i] = 1'b0;
                    age_next[i]   = '0;
                end
                else if (valid_reg[i] && (age_reg[i] > hit_age))
                begin
                    age_next[i] = age_reg[i] - AW'(1);
                end
            end
            else if (do_insert)
            begin
                // The evicted slot, if any, is reused for the new entry.
                if (new_sel[i])
                begin
                    valid_next[i] = 1'b1;
                    age_next[i]   = '0;
                end
                else if (valid_reg[i])
                begin
                    age_next[i] = age_reg[i] + AW'(1);
                end
            end
        end

        if (do_erase)
            count_next = count_reg - CW'(1);
        else if (do_insert && !do_evict)
            count_next = count_reg + CW'(1);

        occ_x           = XW'(count_next);
        rsp.hit         = hit_op;
        rsp.value_out   = hit_op ? hit_value : '0;
        rsp.inserted    = do_insert;
        rsp.evicted     = do_evict;
        rsp.evicted_key = do_evict ? evict_key : '0;
        rsp.occupancy   = occ_x[lkv_pkg::OCC_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            limit_reg <= lkv_pkg::LIMIT_RESET;
            for (int i = 0; i < CAPACITY; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
                limit_reg <= cfg_wr_data;
            if (accept)
            begin
                valid_reg <= valid_next;
                count_reg <= count_next;
                for (int i = 0; i < CAPACITY; i++)
                begin
                    age_reg[i] <= age_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && do_insert)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (new_sel[i])
                begin
                    key_reg[i]   <= req.key_in;
                    value_reg[i] <= req.value_in;
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/lkv_out_buf.sv
// ----------------------------------------------------------------------------
// lkv_out_buf: response register with a skid stage
// Keeps accepting one beat while the response register is stalled, so the
// request side only stalls once both stages are full.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    input  lkv_pkg::lkv_rsp_t push_data,
    output logic              push_stall,
    output logic              pop_valid,
    input  logic              pop_stall,
    output lkv_pkg::lkv_rsp_t pop_data
);

    logic              main_valid_reg;
    logic              skid_valid_reg;
    lkv_pkg::lkv_rsp_t main_reg;
    lkv_pkg::lkv_rsp_t skid_reg;
    logic              pop;
    logic              push;

    assign pop        = main_valid_reg && !pop_stall;
    assign push       = push_valid && !skid_valid_reg;
    assign push_stall = skid_valid_reg;
    assign pop_valid  = main_valid_reg;
    assign pop_data   = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                main_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                main_reg <= skid_reg;
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
                skid_reg <= push_data;
            else
                main_reg <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/lkv_checker.sv
// ----------------------------------------------------------------------------
// lkv_checker: port-level checks for the LRU key-value cache
// Watches the channel ports and the response fields over time.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_stall,
    input logic              rsp_valid,
    input logic              rsp_stall,
    input lkv_pkg::lkv_rsp_t rsp
);

    // A stalled response beat stays and holds its payload.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response beat changed while stalled");

    // The request side only stalls when a response is waiting.
    a_stall_needs_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid)
        else $error("request stalled with no response pending");

    // Accepting a beat while the response is stalled fills the skid stage.
    a_skid_fills: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall && req_valid && !req_stall |=> req_stall)
        else $error("second beat accepted without stalling the request side");

    // A request accepted while nothing is buffered shows up in the next cycle.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && !rsp_valid |=> rsp_valid)
        else $error("response missing one cycle after an accepted request");

    // An eviction only happens as part of adding a new entry.
    a_evict_insert: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.evicted |-> rsp.inserted && !rsp.hit)
        else $error("eviction reported without a new entry");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (.*);

`default_nettype wire
